### src/ils_pkg.sv
// Shared types and constants for the indexed list store.
`timescale 1ns / 1ps
`default_nettype none

package ils_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Command codes
    typedef enum logic [2:0] {
        CMD_READ   = 3'd0,
        CMD_APPEND = 3'd1,
        CMD_WRITE  = 3'd2,
        CMD_POP    = 3'd3,
        CMD_INSERT = 3'd4,
        CMD_REMOVE = 3'd5
    } cmd_e;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_INDEX = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_e;

    // Per-cell operation
    typedef enum logic [1:0] {
        CELL_HOLD    = 2'd0,
        CELL_LOAD    = 2'd1,
        CELL_FROM_LO = 2'd2,
        CELL_FROM_HI = 2'd3
    } cell_op_e;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [4:0]  position;
        logic [31:0] value;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [4:0]  length;
        logic [1:0]  status;
    } rsp_t;

endpackage

`default_nettype wire

### src/ils_cell.sv
// One storage cell of the list chain: holds a word, loads or takes a neighbor's word.
`timescale 1ns / 1ps
`default_nettype none

module ils_cell (
    input  wire logic                           clk,
    input  wire ils_pkg::cell_op_e              op,
    input  wire logic [ils_pkg::DATA_WIDTH-1:0] load_data,
    input  wire logic [ils_pkg::DATA_WIDTH-1:0] lo_data,
    input  wire logic [ils_pkg::DATA_WIDTH-1:0] hi_data,
    output logic      [ils_pkg::DATA_WIDTH-1:0] data
);

    logic [ils_pkg::DATA_WIDTH-1:0] data_reg;
    logic [ils_pkg::DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        case (op)
            ils_pkg::CELL_LOAD:    data_next = load_data;
            ils_pkg::CELL_FROM_LO: data_next = lo_data;
            ils_pkg::CELL_FROM_HI: data_next = hi_data;
            default:               data_next = data_reg;
        endcase
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

### src/indexed_list_store_unit.sv
// Top level of the indexed list store: command decode, cell chain and result register.
`timescale 1ns / 1ps
`default_nettype none
// A request accepted at one clock edge has its result valid after that edge.
// Throughput: one request per cycle while the input is not stalled; every command, insert and
//   remove included, finishes in the cycle it is accepted because all cells shift in parallel.
// A request is taken whenever the result register is empty or being taken in the same cycle.
// Reset clears the element count and the result valid flag; stored words are not reset and
//   are never read before they are written.

module indexed_list_store_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire ils_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output ils_pkg::rsp_t      rsp
);

    localparam int DW    = ils_pkg::DATA_WIDTH;
    localparam int CNT_W = ils_pkg::CNT_W;
    localparam int IDX_W = ils_pkg::IDX_W;

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    ils_pkg::rsp_t      rsp_reg;
    ils_pkg::rsp_t      rsp_next;

    logic               req_accept;
    logic [CNT_W-1:0]   pos;
    logic               full;
    logic               empty;
    logic               in_range;   // pos < count
    logic               ins_range;  // pos <= count

    // decoded actions, qualified by success
    logic               do_append;
    logic               do_load_pos;
    logic               do_shift_up;
    logic               do_shift_down;
    logic               do_read;
    logic               do_pop;
    ils_pkg::status_e   status;

    logic [IDX_W-1:0]   rd_idx;
    logic [DW-1:0]      rd_word;

    logic [DW-1:0]           cell_data [ils_pkg::DEPTH];
    ils_pkg::cell_op_e       cell_op   [ils_pkg::DEPTH];

    // ---------------------------------------------------------------
    // Handshake: input stalls only while a result waits and is stalled
    // ---------------------------------------------------------------
    assign req_stall  = rsp_valid_reg && rsp_stall;
    assign req_accept = req_valid && !req_stall;

    assign pos       = req.position;
    assign full      = (count_reg == CNT_W'(ils_pkg::DEPTH));
    assign empty     = (count_reg == '0);
    assign in_range  = (pos < count_reg);
    assign ins_range = (pos <= count_reg);

    // ---------------------------------------------------------------
    // Command decode: status, count update and which cells move
    // ---------------------------------------------------------------
    always_comb
    begin
        do_append     = 1'b0;
        do_load_pos   = 1'b0;
        do_shift_up   = 1'b0;
        do_shift_down = 1'b0;
        do_read       = 1'b0;
        do_pop        = 1'b0;
        status        = ils_pkg::ST_OK;
        count_next    = count_reg;
        unique case (req.cmd)
            ils_pkg::CMD_READ:
            begin
                if (!in_range)
                    status = ils_pkg::ST_INDEX;
                else
                    do_read = 1'b1;
            end
            ils_pkg::CMD_APPEND:
            begin
                if (full)
                    status = ils_pkg::ST_FULL;
                else
                    do_append = 1'b1;
            end
            ils_pkg::CMD_WRITE:
            begin
                if (!in_range)
                    status = ils_pkg::ST_INDEX;
                else
                    do_load_pos = 1'b1;
            end
            ils_pkg::CMD_POP:
            begin
                if (empty)
                    status = ils_pkg::ST_EMPTY;
                else
                    do_pop = 1'b1;
            end
            ils_pkg::CMD_INSERT:
            begin
                // full check wins over the index check
                if (full)
                    status = ils_pkg::ST_FULL;
                else if (!ins_range)
                    status = ils_pkg::ST_INDEX;
                else
                begin
                    do_load_pos = 1'b1;
                    do_shift_up = 1'b1;
                end
            end
            ils_pkg::CMD_REMOVE:
            begin
                // empty check wins over the index check
                if (empty)
                    status = ils_pkg::ST_EMPTY;
                else if (!in_range)
                    status = ils_pkg::ST_INDEX;
                else
                    do_shift_down = 1'b1;
            end
            default:
            begin
                // unknown command: no change, status ok
            end
        endcase

        if (do_append || do_shift_up)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop || do_shift_down)
            count_next = count_reg - CNT_W'(1);
    end

    // ---------------------------------------------------------------
    // Cell chain: each cell sees its own index and picks its move
    // ---------------------------------------------------------------
    for (genvar i = 0; i < ils_pkg::DEPTH; i++)
    begin : g_cell
        localparam logic [CNT_W-1:0] CellIdx  = CNT_W'(i);
        localparam logic [CNT_W-1:0] CellNext = CNT_W'(i + 1);

        logic [DW-1:0] lo_word;
        logic [DW-1:0] hi_word;

        // chain ends see zero
        if (i == 0)
        begin : g_lo_end
            assign lo_word = '0;
        end
        else
        begin : g_lo
            assign lo_word = cell_data[i-1];
        end

        if (i == ils_pkg::DEPTH - 1)
        begin : g_hi_end
            assign hi_word = '0;
        end
        else
        begin : g_hi
            assign hi_word = cell_data[i+1];
        end

        always_comb
        begin
            cell_op[i] = ils_pkg::CELL_HOLD;
            if (req_accept)
            begin
                if (do_append && (CellIdx == count_reg))
                    cell_op[i] = ils_pkg::CELL_LOAD;
                else if (do_load_pos && (CellIdx == pos))
                    cell_op[i] = ils_pkg::CELL_LOAD;
                else if (do_shift_up && (CellIdx > pos) && (CellIdx <= count_reg))
                    cell_op[i] = ils_pkg::CELL_FROM_LO;
                else if (do_shift_down && (CellIdx >= pos) && (CellNext < count_reg))
                    cell_op[i] = ils_pkg::CELL_FROM_HI;
            end
        end

        ils_cell u_cell (
            .clk       (clk),
            .op        (cell_op[i]),
            .load_data (req.value),
            .lo_data   (lo_word),
            .hi_data   (hi_word),
            .data      (cell_data[i])
        );
    end

    // ---------------------------------------------------------------
    // Read port: pop reads the last element, read takes the position
    // ---------------------------------------------------------------
    always_comb
    begin
        if (do_pop)
            rd_idx = IDX_W'(count_reg - CNT_W'(1));
        else
            rd_idx = pos[IDX_W-1:0];
    end

    assign rd_word = cell_data[rd_idx];

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_comb
    begin
        rsp_next           = rsp_reg;
        rsp_valid_next     = rsp_valid_reg && rsp_stall;
        if (req_accept)
        begin
            rsp_valid_next     = 1'b1;
            rsp_next.read_data = (do_read || do_pop) ? rd_word : '0;
            rsp_next.length    = count_next;
            rsp_next.status    = status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_accept)
                count_reg <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ils_pkg::DEPTH))
        else $error("element count above depth");

    a_len_matches: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.length == count_reg))
        else $error("result length differs from element count");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.status != ils_pkg::ST_OK)) |-> (rsp_reg.read_data == '0))
        else $error("nonzero read data on failed request");

    a_count_only_on_req: assert property (@(posedge clk) disable iff (!rst_n)
        !req_accept |=> (count_reg == $past(count_reg)))
        else $error("element count changed without a request");

    a_full_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (req_accept && full) |=> (count_reg <= $past(count_reg)))
        else $error("full list grew");

endmodule

`default_nettype wire
